FILE: src/rcem_pkg.sv
// shared types, constants and result formatting for the run-collapsed extrema marker
package rcem_pkg;

  localparam int RUN_BITS = 16;
  localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] MARK_NONE = 8'h00;
  localparam logic [7:0] MARK_MAX  = 8'h01;
  localparam logic [7:0] MARK_MIN  = 8'hFF;

  typedef struct packed {
    logic [7:0] sample;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] run_length;
    logic [14:0] zeros_before;
    logic [7:0]  mark_byte;
    logic [15:0] zeros_after;
    logic        last_run;
  } out_item_t;

  function automatic out_item_t make_result(logic [RUN_BITS-1:0] len, logic [7:0] mark,
                                            logic last);
    logic [RUN_BITS-1:0] len_m1;
    logic [RUN_BITS-1:0] lead;
    logic [RUN_BITS-1:0] after;
    out_item_t           res;
    len_m1           = len - RUN_BITS'(1);
    lead             = len_m1 >> 1;
    after            = len_m1 - lead;
    res.run_length   = 16'(len);
    res.zeros_before = 15'(lead);
    res.mark_byte    = mark;
    res.zeros_after  = 16'(after);
    res.last_run     = last;
    return res;
  endfunction

endpackage

FILE: src/rcem_fifo.sv
// result queue taking up to two items per cycle and releasing one
module rcem_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_cnt_i,
  input  rcem_pkg::out_item_t push_a_i,
  input  rcem_pkg::out_item_t push_b_i,
  input  logic                pop_i,
  output logic                not_empty_o,
  output logic                room_two_o,
  output rcem_pkg::out_item_t head_o
);
  import rcem_pkg::*;

  out_item_t             mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_pop;

  assign not_empty_o = (cnt_q != '0);
  assign room_two_o  = (cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign head_o      = mem_q[rd_ptr_q];
  assign do_pop      = pop_i && not_empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q + FIFO_PTR_W'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + FIFO_PTR_W'(do_pop);
    cnt_d    = cnt_q + FIFO_CNT_W'(push_cnt_i) - FIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push_a_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_q + FIFO_PTR_W'(1)] <= push_b_i;
    end
  end

endmodule

FILE: src/run_collapsed_extrema_marker.sv
// top level: run collapsing, extrema marking and result queue
//
// usage
//   input channel: one sample byte per item, with is_last on the final byte of a
//   stream; an item is taken when in_valid_i is high and in_stall_o is low
//   output channel: one run result per item (length, zero padding around the
//   marker, marker byte, last flag); taken when out_valid_o is high and
//   out_stall_i is low
//   config channel: cfg_data_i[0] is signed_mode, written when cfg_valid_i and
//   cfg_ready_o are high; cfg_ready_o is always high
// timing
//   the results a sample closes land in a four-deep queue at the accepting edge and
//   appear on the output in the next cycle if nothing was queued ahead of them
//   one sample per cycle while each sample closes at most one run and the output
//   does not stall; a sample that also ends the stream yields two results, and the
//   single-read queue port then sets the rate to one result per cycle
// reset
//   no run open, no left neighbor, signed_mode = 1, queue empty
// back-pressure
//   a stalled output holds its item; the input stalls once fewer than two queue
//   slots are free, so no result is ever dropped
module run_collapsed_extrema_marker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rcem_pkg::in_item_t in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rcem_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);
  import rcem_pkg::*;

  // run tracking state
  logic                signed_mode_q;
  logic [7:0]          left_value_q, left_value_d;
  logic                left_valid_q, left_valid_d;
  logic [7:0]          run_value_q, run_value_d;
  logic [RUN_BITS-1:0] run_count_q, run_count_d;
  logic                run_valid_q, run_valid_d;

  logic      in_acc;
  logic      room_two;
  logic [1:0] push_cnt;
  out_item_t res_a, res_b, closed_res, last_res;
  logic      closed;
  logic [8:0] key_left, key_run, key_new;
  logic [7:0] mark;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !room_two;
  assign in_acc      = in_valid_i && !in_stall_o;

  // order key: flip the sign bit in signed mode so a plain unsigned compare works
  always_comb begin
    key_left = {1'b0, left_value_q[7] ^ signed_mode_q, left_value_q[6:0]};
    key_run  = {1'b0, run_value_q[7] ^ signed_mode_q, run_value_q[6:0]};
    key_new  = {1'b0, in_item_i.sample[7] ^ signed_mode_q, in_item_i.sample[6:0]};
    if (!left_valid_q) begin
      mark = MARK_NONE;  // first run of a stream has no left neighbor
    end else if (key_run > key_left && key_run > key_new) begin
      mark = MARK_MAX;
    end else if (key_run < key_left && key_run < key_new) begin
      mark = MARK_MIN;
    end else begin
      mark = MARK_NONE;
    end
  end

  always_comb begin
    left_value_d = left_value_q;
    left_valid_d = left_valid_q;
    run_value_d  = run_value_q;
    run_count_d  = run_count_q;
    run_valid_d  = run_valid_q;
    closed       = 1'b0;
    closed_res   = make_result(run_count_q, mark, 1'b0);

    if (!run_valid_q) begin
      // open the first run of a stream
      run_value_d  = in_item_i.sample;
      run_count_d  = RUN_BITS'(1);
      run_valid_d  = 1'b1;
      left_valid_d = 1'b0;
      left_value_d = '0;
    end else if (in_item_i.sample == run_value_q) begin
      if (run_count_q != RUN_MAX) begin
        run_count_d = run_count_q + RUN_BITS'(1);
      end
    end else begin
      // differing sample closes the current run
      closed       = 1'b1;
      left_value_d = run_value_q;
      left_valid_d = 1'b1;
      run_value_d  = in_item_i.sample;
      run_count_d  = RUN_BITS'(1);
    end

    last_res = make_result(run_count_d, MARK_NONE, 1'b1);

    if (in_item_i.is_last) begin
      left_value_d = '0;
      left_valid_d = 1'b0;
      run_value_d  = '0;
      run_count_d  = '0;
      run_valid_d  = 1'b0;
    end

    // closed run goes first, final run second
    res_a    = closed ? closed_res : last_res;
    res_b    = last_res;
    push_cnt = '0;
    if (in_acc) begin
      push_cnt = {1'b0, closed} + {1'b0, in_item_i.is_last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_mode_q <= 1'b1;
      left_value_q  <= '0;
      left_valid_q  <= 1'b0;
      run_value_q   <= '0;
      run_count_q   <= '0;
      run_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        signed_mode_q <= cfg_data_i;
      end
      if (in_acc) begin
        left_value_q <= left_value_d;
        left_valid_q <= left_valid_d;
        run_value_q  <= run_value_d;
        run_count_q  <= run_count_d;
        run_valid_q  <= run_valid_d;
      end
    end
  end

  rcem_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push_a_i    (res_a),
    .push_b_i    (res_b),
    .pop_i       (!out_stall_i),
    .not_empty_o (out_valid_o),
    .room_two_o  (room_two),
    .head_o      (out_item_o)
  );

endmodule

FILE: verif/tb.sv
// testbench for the run-collapsed extrema marker: directed table and random streams
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rcem_pkg::*;

  // table rows either carry one sample or change the compare mode
  typedef enum logic {ROW_SAMPLE, ROW_MODE} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic [7:0] smp;
    logic       fin;
    int         n_typed;   // -1: expectations come from the run predictor
    out_item_t  t0;
    out_item_t  t1;
  } stim_row_t;

  localparam int HALF_PERIOD = 5;
  localparam int MAX_REPORTS = 10;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic      cfg_data_i = 1'b0;

  run_collapsed_extrema_marker DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // run predictor state, a private copy of what the block should hold
  logic                signed_cmp;
  logic [7:0]          prev_val;
  logic                prev_ok;
  logic [7:0]          cur_val;
  logic [RUN_BITS-1:0] cur_cnt;
  logic                cur_ok;

  out_item_t closed_runs[$];   // runs closed by the sample just taken
  out_item_t pending_runs[$];  // run results still owed by the block
  stim_row_t table_rows[$];

  int mismatches = 0;
  int gap_pct    = 22;
  int stall_pct  = 22;

  // ordering key under the current compare mode; equality stays byte equality
  function automatic int ord(logic [7:0] v);
    return signed_cmp ? int'($signed(v)) : int'(v);
  endfunction

  // marker byte sits in the middle of the run, zero padding on both sides
  function automatic out_item_t run_result(logic [RUN_BITS-1:0] len, logic [7:0] mark,
                                           logic fin);
    logic [RUN_BITS-1:0] pad_lo;
    logic [RUN_BITS-1:0] pad_hi;
    out_item_t           r;
    pad_lo         = RUN_BITS'((len - RUN_BITS'(1)) / 2);
    pad_hi         = len - RUN_BITS'(1) - pad_lo;
    r.run_length   = 16'(len);
    r.zeros_before = 15'(pad_lo);
    r.mark_byte    = mark;
    r.zeros_after  = 16'(pad_hi);
    r.last_run     = fin;
    return r;
  endfunction

  function automatic void reset_runs();
    prev_val = '0;
    prev_ok  = 1'b0;
    cur_val  = '0;
    cur_cnt  = '0;
    cur_ok   = 1'b0;
  endfunction

  // one sample through the predictor; closed runs land in closed_runs
  function automatic void advance_runs(in_item_t it);
    logic [7:0] mark;
    closed_runs.delete();
    if (!cur_ok) begin
      // first sample of a stream opens a run with no left neighbor
      cur_val = it.sample;
      cur_cnt = RUN_BITS'(1);
      cur_ok  = 1'b1;
      prev_ok = 1'b0;
      prev_val = '0;
    end else if (it.sample == cur_val) begin
      // length sticks at the counter ceiling
      if (cur_cnt != RUN_MAX) cur_cnt = cur_cnt + RUN_BITS'(1);
    end else begin
      mark = MARK_NONE;
      if (prev_ok) begin
        if (ord(cur_val) > ord(prev_val) && ord(cur_val) > ord(it.sample)) begin
          mark = MARK_MAX;
        end else if (ord(cur_val) < ord(prev_val) && ord(cur_val) < ord(it.sample)) begin
          mark = MARK_MIN;
        end
      end
      closed_runs.push_back(run_result(cur_cnt, mark, 1'b0));
      prev_val = cur_val;
      prev_ok  = 1'b1;
      cur_val  = it.sample;
      cur_cnt  = RUN_BITS'(1);
    end
    // end of stream: the open run goes out unmarked and all run state clears
    if (it.is_last) begin
      closed_runs.push_back(run_result(cur_cnt, MARK_NONE, 1'b1));
      reset_runs();
    end
  endfunction

  function automatic void add_row(row_kind_e k, logic [7:0] s, logic f, int n,
                                  out_item_t a = '0, out_item_t b = '0);
    stim_row_t r;
    r.kind    = k;
    r.smp     = s;
    r.fin     = f;
    r.n_typed = n;
    r.t0      = a;
    r.t1      = b;
    table_rows.push_back(r);
  endfunction

  function automatic void flag(string what, out_item_t e, out_item_t a);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t %s: expected len=%0d zb=%0d mark=%0h za=%0d last=%0b",
               $time, what, e.run_length, e.zeros_before, e.mark_byte, e.zeros_after,
               e.last_run);
      $display("%0t %s:   actual len=%0d zb=%0d mark=%0h za=%0d last=%0b",
               $time, what, a.run_length, a.zeros_before, a.mark_byte, a.zeros_after,
               a.last_run);
    end
  endfunction

  // hand one sample over, with random gaps ahead of it; n_typed >= 0 overrides
  // the predicted runs with the ones given
  task automatic push_sample(logic [7:0] s, logic f, int n_typed = -1,
                             out_item_t a = '0, out_item_t b = '0);
    in_item_t it;
    it.sample  = s;
    it.is_last = f;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    advance_runs(it);
    if (n_typed < 0) begin
      foreach (closed_runs[i]) pending_runs.push_back(closed_runs[i]);
    end else begin
      if (n_typed > 0) pending_runs.push_back(a);
      if (n_typed > 1) pending_runs.push_back(b);
    end
  endtask

  // sender holds off until every owed run has come out, then waits idle before returning
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // mode writes only once the block is idle; an open stream may stay open
  task automatic set_mode(logic m);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    signed_cmp = m;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_val();
    logic [7:0] corners[4];
    corners = '{8'h00, 8'h7F, 8'h80, 8'hFF};
    case ($urandom_range(3))
      0:       return corners[2'($urandom_range(3))];
      1:       return 8'($urandom_range(3) + 8'h7E);   // straddles the sign change
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // mostly well-formed streams of runs, with some loose noise samples
  task automatic random_phase(int n_items);
    int         sent;
    int         n_runs;
    int         len;
    logic       closes;
    logic [7:0] v;
    logic [7:0] last_v;
    sent = 0;
    last_v = cur_val;
    while (sent < n_items) begin
      if ($urandom_range(99) < 12) begin
        v = 8'($urandom_range(255));
        push_sample(v, $urandom_range(3) == 0);
        last_v = v;
        sent++;
      end else begin
        n_runs = $urandom_range(1, 8);
        closes = $urandom_range(99) < 80;
        for (int r = 0; r < n_runs; r++) begin
          do v = pick_val(); while (v == last_v);
          len = ($urandom_range(19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
          for (int k = 0; k < len; k++) begin
            push_sample(v, closes && r == n_runs - 1 && k == len - 1);
            sent++;
          end
          last_v = v;
        end
      end
    end
  endtask

  // output side stalls at random, except in the quiet stretch
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // result checker: each taken result against the oldest owed run
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_runs.size() == 0) begin
        flag("result with nothing owed", '0, out_item_o);
      end else begin
        if (pending_runs[0].run_length   != out_item_o.run_length   ||
            pending_runs[0].zeros_before != out_item_o.zeros_before ||
            pending_runs[0].mark_byte    != out_item_o.mark_byte    ||
            pending_runs[0].zeros_after  != out_item_o.zeros_after  ||
            pending_runs[0].last_run     != out_item_o.last_run) begin
          flag("run result mismatch", pending_runs[0], out_item_o);
        end
        void'(pending_runs.pop_front());
      end
    end
  end

  // hard stop in case something hangs
  initial begin
    #6_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    signed_cmp = 1'b1;
    reset_runs();

    // directed table, starting in signed mode after reset
    // single-sample stream: one unmarked final run
    add_row(ROW_SAMPLE, 8'h05, 1'b1, 1, out_item_t'{16'd1, 15'd0, MARK_NONE, 16'd0, 1'b1});
    add_row(ROW_SAMPLE, 8'h00, 1'b0, 0);
    // first run of a stream is never marked
    add_row(ROW_SAMPLE, 8'h7F, 1'b0, 1, out_item_t'{16'd1, 15'd0, MARK_NONE, 16'd0, 1'b0});
    add_row(ROW_SAMPLE, 8'h7F, 1'b0, -1);
    add_row(ROW_SAMPLE, 8'h7F, 1'b0, -1);
    // signed: 0x7F tops both 0x00 and 0x80
    add_row(ROW_SAMPLE, 8'h80, 1'b0, 1, out_item_t'{16'd3, 15'd1, MARK_MAX, 16'd1, 1'b0});
    // signed: 0x80 is below 0x7F and 0xFF
    add_row(ROW_SAMPLE, 8'hFF, 1'b0, 1, out_item_t'{16'd1, 15'd0, MARK_MIN, 16'd0, 1'b0});
    add_row(ROW_SAMPLE, 8'hFF, 1'b1, 1, out_item_t'{16'd2, 15'd0, MARK_NONE, 16'd1, 1'b1});
    add_row(ROW_SAMPLE, 8'h10, 1'b0, 0);
    add_row(ROW_SAMPLE, 8'h20, 1'b0, 1, out_item_t'{16'd1, 15'd0, MARK_NONE, 16'd0, 1'b0});
    // a differing sample that also ends the stream: two results from one item
    add_row(ROW_SAMPLE, 8'h10, 1'b1, 2, out_item_t'{16'd1, 15'd0, MARK_MAX, 16'd0, 1'b0},
            out_item_t'{16'd1, 15'd0, MARK_NONE, 16'd0, 1'b1});
    add_row(ROW_SAMPLE, 8'h80, 1'b0, 0);
    add_row(ROW_SAMPLE, 8'h01, 1'b0, 1, out_item_t'{16'd1, 15'd0, MARK_NONE, 16'd0, 1'b0});
    // switch to unsigned while the stream is open
    add_row(ROW_MODE, 8'h00, 1'b0, 0);
    // unsigned: 0x01 below 0x80 and 0xFF (signed would call it a maximum)
    add_row(ROW_SAMPLE, 8'hFF, 1'b0, 1, out_item_t'{16'd1, 15'd0, MARK_MIN, 16'd0, 1'b0});
    add_row(ROW_SAMPLE, 8'h00, 1'b0, 1, out_item_t'{16'd1, 15'd0, MARK_MAX, 16'd0, 1'b0});
    add_row(ROW_SAMPLE, 8'h00, 1'b0, -1);
    add_row(ROW_SAMPLE, 8'h00, 1'b0, -1);
    add_row(ROW_SAMPLE, 8'h00, 1'b0, -1);
    // plateau of four: one zero before the marker, two after
    add_row(ROW_SAMPLE, 8'h7F, 1'b1, 2, out_item_t'{16'd4, 15'd1, MARK_MIN, 16'd2, 1'b0},
            out_item_t'{16'd1, 15'd0, MARK_NONE, 16'd0, 1'b1});
    add_row(ROW_MODE, 8'h01, 1'b0, 0);
    add_row(ROW_SAMPLE, 8'h33, 1'b0, -1);
    // rising through a run: neither maximum nor minimum
    add_row(ROW_SAMPLE, 8'h44, 1'b0, -1);
    add_row(ROW_SAMPLE, 8'h55, 1'b1, 2, out_item_t'{16'd1, 15'd0, MARK_NONE, 16'd0, 1'b0},
            out_item_t'{16'd1, 15'd0, MARK_NONE, 16'd0, 1'b1});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[i]) begin
      if (table_rows[i].kind == ROW_MODE) begin
        set_mode(table_rows[i].smp[0]);
      end else begin
        push_sample(table_rows[i].smp, table_rows[i].fin, table_rows[i].n_typed,
                    table_rows[i].t0, table_rows[i].t1);
      end
    end

    // random streams; both modes early, then random, with one quiet phase
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 0) begin
        set_mode(1'b0);
      end else if (ph == 1) begin
        set_mode(1'b1);
      end else begin
        set_mode($urandom_range(1));
      end
      gap_pct   = (ph == 5) ? 0 : 22;
      stall_pct = (ph == 5) ? 0 : 22;
      random_phase(105);
    end

    // wind down: everything owed must arrive, then the bench idles before the final check
    in_valid_i <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (pending_runs.size() != 0) flag("run result never came", pending_runs[0], '0);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: run_collapsed_extrema_marker.f
src/rcem_pkg.sv
src/rcem_fifo.sv
src/run_collapsed_extrema_marker.sv
verif/tb.sv
